### design/sfsc_pkg.sv
// Shared types, constants and arithmetic helpers of the stereo filter and saturation chain.
package sfsc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEFF_BITS  = 20;
	localparam int CHANNELS    = 2;
	localparam int DELAY_BITS  = 32;
	localparam int SFRAC       = SAMPLE_BITS - 1;
	localparam int CFRAC       = COEFF_BITS - 2;
	localparam int GUARD       = 4;
	localparam int STATE_SHIFT = CFRAC - GUARD;
	localparam int CFG_BITS    = 3 * COEFF_BITS;
	localparam int CFG_ADDR_BITS = 3;
	localparam int GAIN_BITS   = 16;
	localparam int BLEND_BITS  = 17;
	localparam int MUL_BITS    = SAMPLE_BITS + 3;
	localparam int WIDE_BITS   = 2 * MUL_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEFF_BITS-1:0]  coeff_t;
	typedef logic signed [DELAY_BITS-1:0]  delay_t;
	typedef logic signed [WIDE_BITS-1:0]   wide_t;

	localparam logic [BLEND_BITS-1:0] BLEND_ONE = BLEND_BITS'(65536);

	// Register indexes of the configuration port
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_HIGHPASS = 3'd0,
		REG_TILT     = 3'd1,
		REG_DRIVE    = 3'd2,
		REG_GLUE     = 3'd3,
		REG_MIX      = 3'd4,
		REG_TRIM     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		coeff_t                hb0;
		coeff_t                ha1;
		coeff_t                ha2;
		coeff_t                tb0;
		coeff_t                ta1;
		coeff_t                ta2;
		logic [GAIN_BITS-1:0]  drive;
		logic [BLEND_BITS-1:0] glue;
		logic [BLEND_BITS-1:0] mix;
		logic [GAIN_BITS-1:0]  trim;
	} cfg_t;

	typedef struct packed {
		logic    done;
		sample_t res;
	} lane_out_t;

	// Round half up, then drop n fraction bits
	function automatic wide_t rshr(input wide_t v, input int n);
		wide_t h;
		h = wide_t'(1) <<< (n - 1);
		return (v + h) >>> n;
	endfunction

	function automatic sample_t sat_sample(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< SFRAC) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi)
			return sample_t'(hi);
		else if (v < lo)
			return sample_t'(lo);
		else
			return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic delay_t sat_delay(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (DELAY_BITS - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi)
			return delay_t'(hi);
		else if (v < lo)
			return delay_t'(lo);
		else
			return v[DELAY_BITS-1:0];
	endfunction

endpackage

### design/stereo_filter_saturation_chain_unit.sv
// Top level of the stereo filter and saturation chain: config registers, lanes, output stage.
//
//  channel  signals                                   width
//  input    in_valid, in_ready, left_in, right_in     24 + 24
//  output   out_valid, out_ready, left_out, right_out 24 + 24
//  config   cfg_we, cfg_addr, cfg_wdata               3 + 60
//
// Each lane runs an item as a sequence of 12 multiplies on its one shared multiplier and table
// port, and the result then goes to the output register.
// Both channels run in parallel lanes; the next item is taken once the result is loaded.
// Reset clears the filter delays and loads the register defaults; no clearing pass.
// A result not taken holds in the output register; the lanes then wait with theirs.
module stereo_filter_saturation_chain_unit #(
	parameter int TANH_ENTRIES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sfsc_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [sfsc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sfsc_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [sfsc_pkg::SAMPLE_BITS-1:0] right_out,
	input  logic                                 cfg_we,
	input  logic [sfsc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [sfsc_pkg::CFG_BITS-1:0]        cfg_wdata
);

	localparam int CB = sfsc_pkg::COEFF_BITS;

	logic [sfsc_pkg::CFG_BITS-1:0]   hp_q;
	logic [sfsc_pkg::CFG_BITS-1:0]   tl_q;
	logic [sfsc_pkg::GAIN_BITS-1:0]  drive_q;
	logic [sfsc_pkg::BLEND_BITS-1:0] glue_q;
	logic [sfsc_pkg::BLEND_BITS-1:0] mix_q;
	logic [sfsc_pkg::GAIN_BITS-1:0]  trim_q;
	logic                            busy_q;
	logic                            accept;
	logic                            ack;
	sfsc_pkg::cfg_t                  cfg;
	sfsc_pkg::sample_t               dry [sfsc_pkg::CHANNELS];
	sfsc_pkg::lane_out_t             lanes [sfsc_pkg::CHANNELS];
	sfsc_pkg::sample_t               res [sfsc_pkg::CHANNELS];

	// Write configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q    <= '0;
			tl_q    <= '0;
			drive_q <= sfsc_pkg::GAIN_BITS'(23757);
			glue_q  <= sfsc_pkg::BLEND_BITS'(32768);
			mix_q   <= sfsc_pkg::BLEND_BITS'(42598);
			trim_q  <= sfsc_pkg::GAIN_BITS'(16384);
		end else if (cfg_we) begin
			case (cfg_addr)
				sfsc_pkg::REG_HIGHPASS: hp_q    <= cfg_wdata;
				sfsc_pkg::REG_TILT:     tl_q    <= cfg_wdata;
				sfsc_pkg::REG_DRIVE:    drive_q <= cfg_wdata[sfsc_pkg::GAIN_BITS-1:0];
				sfsc_pkg::REG_GLUE:     glue_q  <= cfg_wdata[sfsc_pkg::BLEND_BITS-1:0];
				sfsc_pkg::REG_MIX:      mix_q   <= cfg_wdata[sfsc_pkg::BLEND_BITS-1:0];
				sfsc_pkg::REG_TRIM:     trim_q  <= cfg_wdata[sfsc_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Unpack coefficients and limit blend amounts to one
	always_comb begin
		cfg.hb0   = hp_q[CB-1:0];
		cfg.ha1   = hp_q[2*CB-1:CB];
		cfg.ha2   = hp_q[3*CB-1:2*CB];
		cfg.tb0   = tl_q[CB-1:0];
		cfg.ta1   = tl_q[2*CB-1:CB];
		cfg.ta2   = tl_q[3*CB-1:2*CB];
		cfg.drive = drive_q;
		cfg.glue  = (glue_q > sfsc_pkg::BLEND_ONE) ? sfsc_pkg::BLEND_ONE : glue_q;
		cfg.mix   = (mix_q > sfsc_pkg::BLEND_ONE) ? sfsc_pkg::BLEND_ONE : mix_q;
		cfg.trim  = trim_q;
	end

	// Take an item whenever the lanes are free
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (accept)
			busy_q <= 1'b1;
		else if (ack)
			busy_q <= 1'b0;
	end

	assign dry[0] = left_in;
	assign dry[1] = right_in;

	for (genvar i = 0; i < sfsc_pkg::CHANNELS; i++) begin : g_lane
		sfsc_lane #(
			.TANH_ENTRIES(TANH_ENTRIES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.dry_in (dry[i]),
			.cfg    (cfg),
			.ack    (ack),
			.lane_o (lanes[i])
		);
	end

	sfsc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lanes     (lanes),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (res),
		.ack       (ack)
	);

	assign left_out  = res[0];
	assign right_out = res[1];

endmodule

### design/sfsc_lane.sv
// One channel lane: two biquads, drive, tanh shaper, blends and trim on a shared multiplier.
module sfsc_lane #(
	parameter int TANH_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sfsc_pkg::sample_t   dry_in,
	input  sfsc_pkg::cfg_t      cfg,
	input  logic                ack,
	output sfsc_pkg::lane_out_t lane_o
);

	localparam int W   = sfsc_pkg::WIDE_BITS;
	localparam int MW  = sfsc_pkg::MUL_BITS;
	localparam int SB  = sfsc_pkg::SAMPLE_BITS;
	localparam int SF  = sfsc_pkg::SFRAC;
	localparam int SSH = sfsc_pkg::STATE_SHIFT;
	localparam int AB  = $clog2(TANH_ENTRIES + 1);
	localparam int FB  = SF + 2;

	typedef logic [SB-1:0] tab_t [TANH_ENTRIES+1];

	// Bit-by-bit unsigned division, used only while building the table
	function automatic longint unsigned udiv(input longint unsigned n, input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4*i/N) in Q1.23 from an integer exp series, squared four times
	function automatic tab_t build_tab();
		tab_t t;
		longint unsigned u;
		longint unsigned term;
		longint          sum;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		for (int i = 0; i <= TANH_ENTRIES; i++) begin
			u = ((longint'(i) << 30) + TANH_ENTRIES / 2) / TANH_ENTRIES;
			term = 64'd1 << 31;
			sum = longint'(term);
			for (int k = 1; k <= 14; k++) begin
				term = udiv(term * u + (longint'(k) << 30), longint'(k) << 31);
				if (k % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			e = (sum > 0) ? longint'(sum) : 64'd0;
			for (int k = 0; k < 4; k++)
				e = (e * e + (64'd1 << 30)) >> 31;
			num = (64'd1 << 31) - e;
			den = (64'd1 << 31) + e;
			t[i] = SB'(udiv((num << SF) + (den >> 1), den));
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	typedef enum logic [22:0] {
		S_IDLE = 23'b1 << 0,
		S_HB0  = 23'b1 << 1,
		S_HY   = 23'b1 << 2,
		S_HA1  = 23'b1 << 3,
		S_HA2  = 23'b1 << 4,
		S_TB0  = 23'b1 << 5,
		S_TY   = 23'b1 << 6,
		S_TA1  = 23'b1 << 7,
		S_TA2  = 23'b1 << 8,
		S_DRV  = 23'b1 << 9,
		S_SHV  = 23'b1 << 10,
		S_POS  = 23'b1 << 11,
		S_RD0  = 23'b1 << 12,
		S_RD1  = 23'b1 << 13,
		S_INT  = 23'b1 << 14,
		S_SHP  = 23'b1 << 15,
		S_GLU  = 23'b1 << 16,
		S_BLD  = 23'b1 << 17,
		S_MIX  = 23'b1 << 18,
		S_MSM  = 23'b1 << 19,
		S_TRM  = 23'b1 << 20,
		S_OUT  = 23'b1 << 21,
		S_DONE = 23'b1 << 22
	} lane_state_t;

	lane_state_t state_q;
	lane_state_t state_d;

	sfsc_pkg::sample_t dry_q;
	sfsc_pkg::sample_t y_q;
	sfsc_pkg::sample_t c_q;
	sfsc_pkg::sample_t b_q;
	sfsc_pkg::sample_t m_q;
	sfsc_pkg::sample_t res_q;
	sfsc_pkg::wide_t   p0_q;
	sfsc_pkg::wide_t   prod_q;
	sfsc_pkg::delay_t  hs_q [2];
	sfsc_pkg::delay_t  ts_q [2];
	logic [FB-1:0]     mag_q;
	logic [FB-1:0]     frac_q;
	logic              neg_q;
	logic              over_q;
	logic [AB-1:0]     idx_q;
	logic [SB-1:0]     lo_q;
	logic [SB-1:0]     rom_q;

	logic signed [MW-1:0] ma;
	logic signed [MW-1:0] mb;
	sfsc_pkg::wide_t acc_h;
	sfsc_pkg::wide_t acc_t;
	sfsc_pkg::wide_t v_w;
	sfsc_pkg::wide_t mag_w;
	sfsc_pkg::wide_t pos_hi;
	sfsc_pkg::wide_t r_w;
	sfsc_pkg::wide_t r16;
	sfsc_pkg::wide_t r14;
	logic [AB-1:0]   idx_d;
	logic [AB-1:0]   rom_addr;

	// Step through the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_HB0;
			S_HB0:  state_d = S_HY;
			S_HY:   state_d = S_HA1;
			S_HA1:  state_d = S_HA2;
			S_HA2:  state_d = S_TB0;
			S_TB0:  state_d = S_TY;
			S_TY:   state_d = S_TA1;
			S_TA1:  state_d = S_TA2;
			S_TA2:  state_d = S_DRV;
			S_DRV:  state_d = S_SHV;
			S_SHV:  state_d = S_POS;
			S_POS:  state_d = S_RD0;
			S_RD0:  state_d = S_RD1;
			S_RD1:  state_d = S_INT;
			S_INT:  state_d = S_SHP;
			S_SHP:  state_d = S_GLU;
			S_GLU:  state_d = S_BLD;
			S_BLD:  state_d = S_MIX;
			S_MIX:  state_d = S_MSM;
			S_MSM:  state_d = S_TRM;
			S_TRM:  state_d = S_OUT;
			S_OUT:  state_d = S_DONE;
			S_DONE: if (ack) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Pick the operands of the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_HB0: begin ma = MW'(cfg.hb0); mb = MW'(dry_q); end
			S_HA1: begin ma = MW'(cfg.ha1); mb = MW'(y_q); end
			S_HA2: begin ma = MW'(cfg.ha2); mb = MW'(y_q); end
			S_TB0: begin ma = MW'(cfg.tb0); mb = MW'(y_q); end
			S_TA1: begin ma = MW'(cfg.ta1); mb = MW'(y_q); end
			S_TA2: begin ma = MW'(cfg.ta2); mb = MW'(y_q); end
			S_DRV: begin ma = MW'(y_q); mb = MW'(cfg.drive); end
			S_POS: begin ma = MW'(mag_q); mb = MW'(TANH_ENTRIES); end
			S_INT: begin ma = MW'(rom_q) - MW'(lo_q); mb = MW'(frac_q); end
			S_GLU: begin ma = MW'(cfg.glue); mb = MW'(c_q) - MW'(y_q); end
			S_MIX: begin ma = MW'(cfg.mix); mb = MW'(b_q) - MW'(dry_q); end
			S_TRM: begin ma = MW'(m_q); mb = MW'(cfg.trim); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// Accumulator sums, shaper index and rounded products
	always_comb begin
		acc_h  = prod_q + (W'(hs_q[0]) <<< SSH);
		acc_t  = prod_q + (W'(ts_q[0]) <<< SSH);
		v_w    = sfsc_pkg::rshr(prod_q, 12);
		mag_w  = v_w[W-1] ? -v_w : v_w;
		pos_hi = prod_q >>> FB;
		if (pos_hi > W'(TANH_ENTRIES - 1))
			idx_d = AB'(TANH_ENTRIES - 1);
		else
			idx_d = pos_hi[AB-1:0];
		r_w = W'(lo_q) + sfsc_pkg::rshr(prod_q, FB);
		if (over_q)
			r_w = (W'(1) <<< SF) - W'(1);
		r16 = sfsc_pkg::rshr(prod_q, 16);
		r14 = sfsc_pkg::rshr(prod_q, 14);
		rom_addr = (state_q == S_RD0) ? idx_d : idx_q + AB'(1);
	end

	// Table read, registered
	always_ff @(posedge clk) begin
		rom_q <= TAB[rom_addr];
	end

	// Multiply and work the datapath
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (state_q)
			S_IDLE: if (start) dry_q <= dry_in;
			S_HY: begin
				y_q  <= sfsc_pkg::sat_sample(sfsc_pkg::rshr(acc_h, sfsc_pkg::CFRAC));
				p0_q <= prod_q;
			end
			S_TY: begin
				y_q  <= sfsc_pkg::sat_sample(sfsc_pkg::rshr(acc_t, sfsc_pkg::CFRAC));
				p0_q <= prod_q;
			end
			S_SHV: begin
				neg_q  <= v_w[W-1];
				over_q <= mag_w >= (W'(1) <<< FB);
				mag_q  <= mag_w[FB-1:0];
			end
			S_RD0: begin
				idx_q  <= idx_d;
				frac_q <= prod_q[FB-1:0];
			end
			S_RD1: lo_q <= rom_q;
			S_SHP: c_q <= neg_q ? -r_w[SB-1:0] : r_w[SB-1:0];
			S_BLD: b_q <= y_q + r16[SB-1:0];
			S_MSM: m_q <= dry_q + r16[SB-1:0];
			S_OUT: res_q <= sfsc_pkg::sat_sample(r14);
			default: ;
		endcase
	end

	// Hold state and delays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hs_q[0] <= '0;
			hs_q[1] <= '0;
			ts_q[0] <= '0;
			ts_q[1] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_HA2: hs_q[0] <= sfsc_pkg::sat_delay(sfsc_pkg::rshr(
					-(p0_q <<< 1) - prod_q + (W'(hs_q[1]) <<< SSH), SSH));
				S_TB0: hs_q[1] <= sfsc_pkg::sat_delay(sfsc_pkg::rshr(p0_q - prod_q, SSH));
				S_TA2: ts_q[0] <= sfsc_pkg::sat_delay(sfsc_pkg::rshr(
					(p0_q <<< 1) - prod_q + (W'(ts_q[1]) <<< SSH), SSH));
				S_DRV: ts_q[1] <= sfsc_pkg::sat_delay(sfsc_pkg::rshr(p0_q - prod_q, SSH));
				default: ;
			endcase
		end
	end

	assign lane_o.done = (state_q == S_DONE);
	assign lane_o.res  = res_q;

endmodule

### design/sfsc_merge.sv
// Output stage: gathers the lane results into one item and holds it until taken.
module sfsc_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  sfsc_pkg::lane_out_t lanes [sfsc_pkg::CHANNELS],
	input  logic                out_ready,
	output logic                out_valid,
	output sfsc_pkg::sample_t   out_data [sfsc_pkg::CHANNELS],
	output logic                ack
);

	logic all_done;
	logic valid_q;

	// Load when every lane is finished and the slot is free or being taken
	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < sfsc_pkg::CHANNELS; i++)
			all_done = all_done & lanes[i].done;
		ack = all_done && (!valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ack)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			for (int i = 0; i < sfsc_pkg::CHANNELS; i++)
				out_data[i] <= lanes[i].res;
		end
	end

	assign out_valid = valid_q;

endmodule
